// ===== rtl/srrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srrf_pkg;

	localparam int SRRF_MAX_SLOT_BYTES = 64;
	localparam int SRRF_MAX_SLOTS      = 16;

	localparam int SLOT_BYTES_W = 7;
	localparam int SLOT_COUNT_W = 5;
	localparam int CFG_DATA_W   = 7;
	localparam int DATA_W       = 8;

	// Request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Configuration register indexes
	localparam logic CFG_SLOT_BYTES = 1'b0;
	localparam logic CFG_SLOT_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_TOOLONG = 2'd3
	} status_t;

	typedef struct packed {
		logic              req_type;
		logic [DATA_W-1:0] data_in;
		logic              byte_valid_in;
		logic              last_in;
	} srrf_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_out;
		logic              byte_valid_out;
		logic              last_out;
		status_t           status;
	} srrf_rsp_t;

	// What the read sequencer shows the rest of the block
	typedef struct packed {
		logic      busy;
		logic      emit;
		srrf_rsp_t rsp;
	} srrf_rd_out_t;

endpackage

`default_nettype wire

// ===== rtl/srrf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/srrf_rd_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srrf_rd_seq
	import srrf_pkg::*;
#(
	parameter int MAX_SLOT_BYTES = SRRF_MAX_SLOT_BYTES,
	parameter int MAX_SLOTS      = SRRF_MAX_SLOTS,
	localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
	localparam int CW  = $clog2(MAX_SLOT_BYTES + 1),
	localparam int BIW = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1,
	localparam int BYTE_DEPTH = MAX_SLOTS * (2 ** BIW),
	localparam int BAW = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              launch,
	input  wire logic [SW-1:0]     slot,
	input  wire logic [CW-1:0]     len_rdata,
	input  wire logic [DATA_W-1:0] byte_rdata,
	output logic      [BAW-1:0]    byte_raddr,
	output srrf_rd_out_t           rd
);

	typedef enum logic [1:0] {
		RS_IDLE,
		RS_LEN,
		RS_STREAM
	} rs_state_t;

	rs_state_t       state_q;
	logic [SW-1:0]   slot_q;
	logic [CW-1:0]   len_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cnt_inc;
	logic [BIW-1:0]  byte_idx;
	logic            is_last;

	assign cnt_inc  = cnt_q + CW'(1);
	assign is_last  = (cnt_inc == len_q);
	// The length read has just returned in RS_LEN, so byte 0 is fetched there;
	// while streaming, the next byte is always one ahead of the one shown.
	assign byte_idx = (state_q == RS_STREAM) ? BIW'(cnt_inc) : '0;
	assign byte_raddr = BAW'({slot_q, byte_idx});

	always_comb begin
		rd.busy               = (state_q != RS_IDLE);
		rd.emit               = 1'b0;
		rd.rsp.data_out       = '0;
		rd.rsp.byte_valid_out = 1'b0;
		rd.rsp.last_out       = 1'b0;
		rd.rsp.status         = ST_OK;
		unique case (state_q)
			RS_IDLE: begin
			end
			RS_LEN: begin
				if (len_rdata == '0) begin
					rd.emit            = 1'b1;
					rd.rsp.last_out    = 1'b1;
				end
			end
			RS_STREAM: begin
				rd.emit               = 1'b1;
				rd.rsp.data_out       = byte_rdata;
				rd.rsp.byte_valid_out = 1'b1;
				rd.rsp.last_out       = is_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
			slot_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				RS_IDLE: begin
					if (launch) begin
						slot_q  <= slot;
						state_q <= RS_LEN;
					end
				end
				RS_LEN: begin
					len_q <= len_rdata;
					cnt_q <= '0;
					if (len_rdata == '0) begin
						state_q <= RS_IDLE;
					end else begin
						state_q <= RS_STREAM;
					end
				end
				RS_STREAM: begin
					cnt_q <= cnt_inc;
					if (is_last) begin
						state_q <= RS_IDLE;
					end
				end
				default: begin
					state_q <= RS_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/slotted_record_ring_fifo_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Record FIFO held as a ring of fixed-size slots in two memories with registered
// reads, one for record bytes and one for record lengths. Write items never make
// the block busy, so while no read holds it busy a record streams in at one byte
// per cycle; the item marked last gives its status result in the following
// cycle. A read of an empty ring likewise answers in the next cycle without
// going busy. A read of a held record keeps busy high for the length lookup and
// then while its bytes stream (only for the lookup with an empty record, whose
// status result follows in the next cycle); byte results are paced by the
// registered reads of the length memory and then the byte memory, and by the
// result register. Results are presented for exactly one cycle with
// result_valid high and cannot be held off by the receiver.
// Neither memory is cleared after reset, so the block is ready at once.
module slotted_record_ring_fifo_core
	import srrf_pkg::*;
#(
	parameter int MAX_SLOT_BYTES = SRRF_MAX_SLOT_BYTES,
	parameter int MAX_SLOTS      = SRRF_MAX_SLOTS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire srrf_req_t             req,
	output logic                       result_valid,
	output srrf_rsp_t                  result,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int FW  = $clog2(MAX_SLOTS + 1);
	localparam int CW  = $clog2(MAX_SLOT_BYTES + 1);
	localparam int BIW = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1;
	localparam int BYTE_DEPTH = MAX_SLOTS * (2 ** BIW);
	localparam int BAW = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;

	logic [SLOT_BYTES_W-1:0] slot_bytes_q;
	logic [SLOT_COUNT_W-1:0] slot_count_q;
	logic [SW-1:0]           write_slot_q, write_slot_n;
	logic [SW-1:0]           read_slot_q, read_slot_n;
	logic [FW-1:0]           filled_q, filled_n;
	logic [CW-1:0]           wcnt_q, wcnt_n;
	status_t                 rerr_q, rerr_n;
	logic                    result_valid_q;
	srrf_rsp_t               result_q;

	logic [CW-1:0]     sb;
	logic [FW-1:0]     sc;
	logic              accept;
	logic              ring_full;
	logic              byte_we;
	logic              len_we;
	logic [CW-1:0]     rec_len;
	logic [BAW-1:0]    byte_waddr;
	logic [BAW-1:0]    byte_raddr;
	logic [DATA_W-1:0] byte_rdata;
	logic [CW-1:0]     len_rdata;
	logic              loc_valid;
	srrf_rsp_t         loc_rsp;
	status_t           rec_st;
	logic              rd_launch;
	srrf_rd_out_t      rd;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s,
			input logic [FW-1:0] n);
		int unsigned nxt;
		nxt = int'(s) + 1;
		return (nxt >= int'(n)) ? '0 : SW'(nxt);
	endfunction

	// Registers are used clamped to the range the storage can hold.
	assign sb = (slot_bytes_q == '0) ? CW'(1) :
		(int'(slot_bytes_q) > MAX_SLOT_BYTES) ? CW'(MAX_SLOT_BYTES) : CW'(slot_bytes_q);
	assign sc = (slot_count_q == '0) ? FW'(1) :
		(int'(slot_count_q) > MAX_SLOTS) ? FW'(MAX_SLOTS) : FW'(slot_count_q);

	assign busy       = rd.busy;
	assign accept     = start && !rd.busy;
	assign ring_full  = (filled_q >= sc);
	assign byte_waddr = BAW'({write_slot_q, wcnt_q[BIW-1:0]});
	assign rd_launch  = accept && (req.req_type == REQ_READ) && (filled_q != '0);

	always_comb begin
		write_slot_n           = write_slot_q;
		read_slot_n            = read_slot_q;
		filled_n               = filled_q;
		wcnt_n                 = wcnt_q;
		rerr_n                 = rerr_q;
		byte_we                = 1'b0;
		len_we                 = 1'b0;
		rec_len                = wcnt_q;
		rec_st                 = ST_OK;
		loc_valid              = 1'b0;
		loc_rsp.data_out       = '0;
		loc_rsp.byte_valid_out = 1'b0;
		loc_rsp.last_out       = 1'b1;
		loc_rsp.status         = ST_OK;
		if (accept) begin
			if (req.req_type == REQ_WRITE) begin
				if (req.byte_valid_in && (rerr_q != ST_TOOLONG)) begin
					if (wcnt_q >= sb) begin
						rerr_n = ST_TOOLONG;
					end else begin
						// A full ring refuses the whole record, even if a slot
						// frees up before its end.
						if (ring_full) begin
							rerr_n = ST_FULL;
						end
						byte_we = (rerr_n == ST_OK);
						rec_len = wcnt_q + CW'(1);
						wcnt_n  = rec_len;
					end
				end
				if (req.last_in) begin
					rec_st = rerr_n;
					if ((rec_st == ST_OK) && (wcnt_n > sb)) begin
						rec_st = ST_TOOLONG;
					end
					if ((rec_st == ST_OK) && ring_full) begin
						rec_st = ST_FULL;
					end
					if (rec_st == ST_OK) begin
						len_we       = 1'b1;
						write_slot_n = next_slot(write_slot_q, sc);
						filled_n     = filled_q + FW'(1);
					end
					wcnt_n         = '0;
					rerr_n         = ST_OK;
					loc_valid      = 1'b1;
					loc_rsp.status = rec_st;
				end
			end else if (filled_q == '0) begin
				loc_valid      = 1'b1;
				loc_rsp.status = ST_EMPTY;
			end else begin
				read_slot_n = next_slot(read_slot_q, sc);
				filled_n    = filled_q - FW'(1);
			end
		end
	end

	srrf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(BYTE_DEPTH)
	) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (byte_waddr),
		.wdata (req.data_in),
		.raddr (byte_raddr),
		.rdata (byte_rdata)
	);

	// The read slot pointer addresses the length memory at all times, so the
	// length is ready the cycle after a read transfer.
	srrf_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_SLOTS)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (write_slot_q),
		.wdata (rec_len),
		.raddr (read_slot_q),
		.rdata (len_rdata)
	);

	srrf_rd_seq #(
		.MAX_SLOT_BYTES(MAX_SLOT_BYTES),
		.MAX_SLOTS     (MAX_SLOTS)
	) u_rd_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.launch     (rd_launch),
		.slot       (read_slot_q),
		.len_rdata  (len_rdata),
		.byte_rdata (byte_rdata),
		.byte_raddr (byte_raddr),
		.rd         (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q   <= SLOT_BYTES_W'(SRRF_MAX_SLOT_BYTES);
			slot_count_q   <= SLOT_COUNT_W'(SRRF_MAX_SLOTS);
			write_slot_q   <= '0;
			read_slot_q    <= '0;
			filled_q       <= '0;
			wcnt_q         <= '0;
			rerr_q         <= ST_OK;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SLOT_BYTES: slot_bytes_q <= cfg_data[SLOT_BYTES_W-1:0];
					CFG_SLOT_COUNT: slot_count_q <= cfg_data[SLOT_COUNT_W-1:0];
					default: begin
					end
				endcase
			end
			write_slot_q   <= write_slot_n;
			read_slot_q    <= read_slot_n;
			filled_q       <= filled_n;
			wcnt_q         <= wcnt_n;
			rerr_q         <= rerr_n;
			result_valid_q <= loc_valid || rd.emit;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= loc_valid ? loc_rsp : rd.rsp;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== rtl/srrf_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srrf_chk
	import srrf_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire srrf_req_t req,
	input wire logic      result_valid,
	input wire srrf_rsp_t result
);

	logic acc_wr, acc_rd;

	assign acc_wr = start && !busy && (req.req_type == REQ_WRITE);
	assign acc_rd = start && !busy && (req.req_type == REQ_READ);

	// A write transfer that does not close a record produces nothing.
	a_wr_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc_wr && !req.last_in |=> !result_valid)
		else $error("result after a write item without last");

	// Closing a record gives exactly one status result with no byte.
	a_wr_close: assert property (@(posedge clk) disable iff (!arst_n)
		acc_wr && req.last_in |=> result_valid && result.last_out && !result.byte_valid_out)
		else $error("missing or malformed status result at record end");

	// A read either answers empty at once or goes busy for the length lookup.
	a_rd_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc_rd |=> (result_valid && !busy && (result.status == ST_EMPTY)) ||
			(busy && !result_valid))
		else $error("unexpected response to a read transfer");

	// Record bytes of one read come out in unbroken consecutive cycles.
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_valid_out && !result.last_out |=>
			result_valid && result.byte_valid_out)
		else $error("gap inside a record read");

	// While results stream, no other transfer can be taken.
	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_valid_out && !result.last_out |-> busy)
		else $error("ready while a record read is still in flight");

endmodule

bind slotted_record_ring_fifo_core srrf_chk u_srrf_chk (.*);

`default_nettype wire
